// File: rtl/core/pidc_pkg.sv
package pidc_pkg;

   // q16.16 word and configuration widths
   localparam int unsigned QWidth     = 32;
   localparam int unsigned StepWidth  = 31;
   localparam int unsigned IndexWidth = 3;

   typedef logic signed [QWidth-1:0] q16_type;

   // configuration register indexes
   localparam logic [IndexWidth-1:0] REG_GAIN_P          = 3'd0;
   localparam logic [IndexWidth-1:0] REG_GAIN_I          = 3'd1;
   localparam logic [IndexWidth-1:0] REG_GAIN_D_PER_STEP = 3'd2;
   localparam logic [IndexWidth-1:0] REG_STEP_TIME       = 3'd3;
   localparam logic [IndexWidth-1:0] REG_INTEGRAL_MAX    = 3'd4;
   localparam logic [IndexWidth-1:0] REG_INTEGRAL_MIN    = 3'd5;
   localparam logic [IndexWidth-1:0] REG_DRIVE_MAX       = 3'd6;
   localparam logic [IndexWidth-1:0] REG_DRIVE_MIN       = 3'd7;

   // item kinds
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // reset values
   localparam q16_type              RST_GAIN_P    = 32'sh0001_0000;
   localparam q16_type              RST_GAIN_I    = 32'sh0000_0000;
   localparam q16_type              RST_GAIN_D    = 32'sh0000_0000;
   localparam logic [StepWidth-1:0] RST_STEP_TIME = 31'h0001_0000;
   localparam q16_type              Q16_MAX       = 32'sh7FFF_FFFF;
   localparam q16_type              Q16_MIN       = 32'sh8000_0000;

   // live configuration seen by the datapath
   typedef struct packed {
      q16_type              gain_p;
      q16_type              gain_i;
      q16_type              gain_d_per_step;
      logic [StepWidth-1:0] step_time;
      q16_type              integral_max;
      q16_type              integral_min;
      q16_type              drive_max;
      q16_type              drive_min;
   } cfg_type;

endpackage

// File: rtl/core/pidc_mul.sv
module pidc_mul (
   input  logic             clock,
   input  pidc_pkg::q16_type op_a,
   input  pidc_pkg::q16_type op_b,
   output pidc_pkg::q16_type q
);

   logic signed [63:0] prod_in;
   logic signed [63:0] prod_ff;
   logic signed [63:0] biased;
   logic signed [47:0] shifted;
   pidc_pkg::q16_type  q_in;
   pidc_pkg::q16_type  q_ff;

   // full signed product, registered
   assign prod_in = op_a * op_b;

   // shift by 16 rounding toward zero, then saturate to 32 bits
   always_comb begin
      biased  = prod_ff[63] ? (prod_ff + 64'sd65535) : prod_ff;
      shifted = $signed(biased[63:16]);
      if (shifted > 48'sh0000_7FFF_FFFF) begin
         q_in = pidc_pkg::Q16_MAX;
      end else if (shifted < -48'sh0000_8000_0000) begin
         q_in = pidc_pkg::Q16_MIN;
      end else begin
         q_in = shifted[31:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q_ff    <= q_in;
   end

   assign q = q_ff;

endmodule

// File: rtl/core/pidc_core.sv
module pidc_core (
   input  logic              clock,
   input  logic              reset,
   input  pidc_pkg::cfg_type cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,   // measured [31:0], setpoint [63:32]
   input  logic              req_tuser,   // kind [0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata    // drive [31:0]
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_ERR   = 10'b00_0000_0010,
      ST_DIFF  = 10'b00_0000_0100,
      ST_MUL_P = 10'b00_0000_1000,
      ST_MUL_D = 10'b00_0001_0000,
      ST_INT   = 10'b00_0010_0000,
      ST_MUL_I = 10'b00_0100_0000,
      ST_WAIT  = 10'b00_1000_0000,
      ST_SUM   = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   function automatic pidc_pkg::q16_type sat32(input logic signed [33:0] v);
      pidc_pkg::q16_type r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = pidc_pkg::Q16_MAX;
      end else if (v < -34'sh0_8000_0000) begin
         r = pidc_pkg::Q16_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   state_type          state_ff, state_in;
   pidc_pkg::q16_type  meas_ff, meas_in;
   pidc_pkg::q16_type  sp_ff, sp_in;
   pidc_pkg::q16_type  err_ff, err_in;
   pidc_pkg::q16_type  diff_ff, diff_in;
   pidc_pkg::q16_type  last_ff, last_in;
   pidc_pkg::q16_type  integ_ff, integ_in;
   pidc_pkg::q16_type  sum_ff, sum_in;
   logic signed [33:0] acc_ff, acc_in;
   pidc_pkg::q16_type  res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   pidc_pkg::q16_type  mul_a, mul_b, mul_q;
   logic signed [33:0] total;
   logic               req_fire;

   pidc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .q     (mul_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign total      = acc_ff + 34'(mul_q);

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DIFF: begin
            mul_a = err_ff;
            mul_b = $signed({1'b0, cfg.step_time});
         end
         ST_MUL_P: begin
            mul_a = cfg.gain_p;
            mul_b = err_ff;
         end
         ST_MUL_D: begin
            mul_a = cfg.gain_d_per_step;
            mul_b = diff_ff;
         end
         ST_MUL_I: begin
            mul_a = cfg.gain_i;
            mul_b = integ_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      meas_in      = meas_ff;
      sp_in        = sp_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      last_in      = last_ff;
      integ_in     = integ_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               meas_in = req_tdata[31:0];
               sp_in   = req_tdata[63:32];
               if (req_tuser == pidc_pkg::KIND_CLEAR) begin
                  integ_in = '0;
                  last_in  = '0;
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            err_in   = sat32(34'(sp_ff) - 34'(meas_ff));
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = sat32(34'(err_ff) - 34'(last_ff));
            last_in  = err_ff;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            // integral plus error times step time
            sum_in   = sat32(34'(integ_ff) + 34'(mul_q));
            state_in = ST_INT;
         end
         ST_INT: begin
            // clamp integral, upper bound first
            if (sum_ff > cfg.integral_max) begin
               integ_in = cfg.integral_max;
            end else if (sum_ff < cfg.integral_min) begin
               integ_in = cfg.integral_min;
            end else begin
               integ_in = sum_ff;
            end
            acc_in   = 34'(mul_q);
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            acc_in   = acc_ff + 34'(mul_q);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // output clamp, upper bound first
            if (total > 34'(cfg.drive_max)) begin
               res_in = cfg.drive_max;
            end else if (total < 34'(cfg.drive_min)) begin
               res_in = cfg.drive_min;
            end else begin
               res_in = total[31:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      sp_ff       <= sp_in;
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      sum_ff      <= sum_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // a clear word zeroes the controller state
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == pidc_pkg::KIND_CLEAR) |=> (integ_ff == '0 && last_ff == '0))
      else $error("clear did not zero integral state");

   // clamped integral stays within consistent bounds
   a_integ_bounds: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_INT) && $past(cfg.integral_min <= cfg.integral_max))
      |-> (integ_ff <= $past(cfg.integral_max) && integ_ff >= $past(cfg.integral_min)))
      else $error("integral outside bounds");

   // a new result word only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside done state");
`endif

endmodule

// File: rtl/core/pid_controller_clamped.sv
// an update word walks the error, difference, product, integral, wait, sum and done states before
// rsp_tvalid rises, a clear word only the done state; a word is taken only when idle; one shared
// 32x32 multiplier serves four products in turn
// the input is taken again while a finished result still waits in the output register
// reset (synchronous, active high) restores register defaults and zeroes integral and last error
module pid_controller_clamped (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // measured [31:0], setpoint [63:32]
   input  logic        req_tuser,   // kind [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drive [31:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   pidc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   // configuration register bank
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pidc_pkg::REG_GAIN_P:          cfg_in.gain_p          = csr_data;
            pidc_pkg::REG_GAIN_I:          cfg_in.gain_i          = csr_data;
            pidc_pkg::REG_GAIN_D_PER_STEP: cfg_in.gain_d_per_step = csr_data;
            pidc_pkg::REG_STEP_TIME:       cfg_in.step_time       = csr_data[30:0];
            pidc_pkg::REG_INTEGRAL_MAX:    cfg_in.integral_max    = csr_data;
            pidc_pkg::REG_INTEGRAL_MIN:    cfg_in.integral_min    = csr_data;
            pidc_pkg::REG_DRIVE_MAX:       cfg_in.drive_max       = csr_data;
            pidc_pkg::REG_DRIVE_MIN:       cfg_in.drive_min       = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= pidc_pkg::RST_GAIN_P;
         cfg_ff.gain_i          <= pidc_pkg::RST_GAIN_I;
         cfg_ff.gain_d_per_step <= pidc_pkg::RST_GAIN_D;
         cfg_ff.step_time       <= pidc_pkg::RST_STEP_TIME;
         cfg_ff.integral_max    <= pidc_pkg::Q16_MAX;
         cfg_ff.integral_min    <= pidc_pkg::Q16_MIN;
         cfg_ff.drive_max       <= pidc_pkg::Q16_MAX;
         cfg_ff.drive_min       <= pidc_pkg::Q16_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pidc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: tb/sv/tb_pid_controller_clamped.sv
module tb_pid_controller_clamped;
   timeunit 1ns;
   timeprecision 1ps;

   import pidc_pkg::*;

   // shadow of the controller: live settings, integral and last error, queued drive words
   class drive_scoreboard;
      longint  gain_p, gain_i, gain_d, step_time;
      longint  integ_max, integ_min, drv_max, drv_min;
      longint  integ_acc, held_err;
      q16_type pending_drive[$];
      int      mismatches;
      int      checked;

      function new();
         gain_p     = RST_GAIN_P;
         gain_i     = RST_GAIN_I;
         gain_d     = RST_GAIN_D;
         step_time  = longint'(RST_STEP_TIME);
         integ_max  = Q16_MAX;
         integ_min  = Q16_MIN;
         drv_max    = Q16_MAX;
         drv_min    = Q16_MIN;
         integ_acc  = 0;
         held_err   = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // q16.16 product, shifted down toward zero, saturated
      function longint qmul(longint a, longint b);
         longint p;
         longint q;
         p = a * b;
         if (p < 0) q = -((-p) >>> 16);
         else q = p >>> 16;
         return sat32(q);
      endfunction

      function void write_reg(logic [IndexWidth-1:0] idx, logic [31:0] val);
         case (idx)
            REG_GAIN_P:          gain_p    = longint'($signed(val));
            REG_GAIN_I:          gain_i    = longint'($signed(val));
            REG_GAIN_D_PER_STEP: gain_d    = longint'($signed(val));
            REG_STEP_TIME:       step_time = longint'(val[StepWidth-1:0]);
            REG_INTEGRAL_MAX:    integ_max = longint'($signed(val));
            REG_INTEGRAL_MIN:    integ_min = longint'($signed(val));
            REG_DRIVE_MAX:       drv_max   = longint'($signed(val));
            REG_DRIVE_MIN:       drv_min   = longint'($signed(val));
            default: ;
         endcase
      endfunction

      function q16_type predict_drive(logic kind, q16_type meas, q16_type setp);
         longint err, p_term, i_term, d_term, total;
         if (kind == KIND_CLEAR) begin
            integ_acc = 0;
            held_err  = 0;
            return '0;
         end
         err    = sat32(longint'(setp) - longint'(meas));
         p_term = qmul(gain_p, err);
         // integral with max checked ahead of min
         integ_acc = sat32(integ_acc + qmul(err, step_time));
         if (integ_acc > integ_max) integ_acc = integ_max;
         else if (integ_acc < integ_min) integ_acc = integ_min;
         i_term = qmul(gain_i, integ_acc);
         d_term = qmul(gain_d, sat32(err - held_err));
         held_err = err;
         total = p_term + i_term + d_term;
         if (total > drv_max) total = drv_max;
         else if (total < drv_min) total = drv_min;
         return total[31:0];
      endfunction

      function void note_word(logic kind, q16_type meas, q16_type setp);
         pending_drive.push_back(predict_drive(kind, meas, setp));
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_drive(logic [31:0] got);
         q16_type want;
         if (pending_drive.size() == 0) begin
            report_mismatch($sformatf("drive word %0d arrived with nothing pending",
                                      $signed(got)));
            return;
         end
         want = pending_drive.pop_front();
         checked++;
         if (got !== want)
            report_mismatch($sformatf("drive word %0d: got %0d expected %0d",
                                      checked, $signed(got), want));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // measured [31:0], setpoint [63:32]
   logic        req_tuser  = 1'b0; // kind [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // drive [31:0]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [31:0] csr_data   = '0;

   drive_scoreboard sb = new();
   bit no_gaps = 1'b0;
   int words_sent = 0;
   int clears_sent = 0;
   int csr_writes = 0;

   pid_controller_clamped dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 9);
   endfunction

   // mix of extremes, zero, values within +-4.0 and raw 32-bit patterns
   function automatic q16_type pick_q16();
      case ($urandom_range(0, 6))
         0: return Q16_MAX;
         1: return Q16_MIN;
         2: return '0;
         3, 4: return q16_type'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: return q16_type'($urandom);
      endcase
   endfunction

   // clamp window, mostly ordered, sometimes full range or inverted
   function automatic void pick_window(output q16_type lo, output q16_type hi);
      q16_type t;
      lo = pick_q16();
      hi = pick_q16();
      case ($urandom_range(0, 7))
         0: begin
            lo = Q16_MIN;
            hi = Q16_MAX;
         end
         1: ;
         default: if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
         end
      endcase
   endfunction

   task automatic send_word(logic kind, q16_type meas, q16_type setp);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {setp, meas};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_word(kind, meas, setp);
      words_sent++;
      if (kind == KIND_CLEAR) clears_sent++;
   endtask

   task automatic end_words();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sb.pending_drive.size() != 0) @(posedge clock);
   endtask

   // write all eight registers in index order
   task automatic write_regs(input logic [31:0] vals [8]);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= IndexWidth'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
         sb.write_reg(IndexWidth'(i), vals[i]);
         csr_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   // result side with random back-pressure
   initial begin : drain
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_drive(rsp_tdata);
      end
   end

   initial begin : stimulus
      logic [31:0] cfg [8];
      q16_type     target, level, lo, hi;
      int          n;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: unity proportional gain, full-range clamps
      send_word(KIND_UPDATE, '0, '0);
      send_word(KIND_UPDATE, 32'sh0001_8000, 32'sh0003_0000);
      send_word(KIND_UPDATE, Q16_MIN, Q16_MAX);   // error saturates high
      send_word(KIND_UPDATE, Q16_MAX, Q16_MIN);   // error saturates low
      send_word(KIND_CLEAR, Q16_MAX, Q16_MIN);
      end_words();
      wait_idle();

      // extreme gains, longest step, narrow windows
      cfg[REG_GAIN_P]          = Q16_MAX;
      cfg[REG_GAIN_I]          = Q16_MIN;
      cfg[REG_GAIN_D_PER_STEP] = Q16_MAX;
      cfg[REG_STEP_TIME]       = 32'hFFFF_FFFF;
      cfg[REG_INTEGRAL_MAX]    = 32'h0010_0000;
      cfg[REG_INTEGRAL_MIN]    = 32'hFFF0_0000;
      cfg[REG_DRIVE_MAX]       = 32'h4000_0000;
      cfg[REG_DRIVE_MIN]       = 32'hC000_0000;
      write_regs(cfg);
      send_word(KIND_UPDATE, Q16_MIN, Q16_MAX);
      send_word(KIND_UPDATE, Q16_MAX, Q16_MIN);   // error difference saturates
      send_word(KIND_UPDATE, 32'shFFFF_8000, 32'sh0000_8000);
      send_word(KIND_UPDATE, 32'sh0001_0000, '0);
      send_word(KIND_CLEAR, '0, '0);
      send_word(KIND_UPDATE, 32'shFFFF_FFFF, '0);
      end_words();
      wait_idle();

      // inverted windows and zero step time
      cfg[REG_GAIN_P]          = Q16_MIN;
      cfg[REG_GAIN_I]          = 32'h0001_0000;
      cfg[REG_GAIN_D_PER_STEP] = Q16_MIN;
      cfg[REG_STEP_TIME]       = 32'h0000_0000;
      cfg[REG_INTEGRAL_MAX]    = 32'hFFFE_0000;
      cfg[REG_INTEGRAL_MIN]    = 32'h0002_0000;
      cfg[REG_DRIVE_MAX]       = 32'hFFFD_0000;
      cfg[REG_DRIVE_MIN]       = 32'h0003_0000;
      write_regs(cfg);
      send_word(KIND_UPDATE, '0, '0);
      send_word(KIND_UPDATE, 32'sh0002_0000, 32'shFFFF_0000);
      send_word(KIND_UPDATE, 32'shFFFF_0000, 32'sh0002_0000);
      send_word(KIND_UPDATE, Q16_MIN, Q16_MAX);
      end_words();
      wait_idle();

      // ordinary integral build-up then clear
      cfg[REG_GAIN_P]          = '0;
      cfg[REG_GAIN_I]          = 32'h0001_0000;
      cfg[REG_GAIN_D_PER_STEP] = 32'h0002_0000;
      cfg[REG_STEP_TIME]       = 32'h0000_8000;
      cfg[REG_INTEGRAL_MAX]    = Q16_MAX;
      cfg[REG_INTEGRAL_MIN]    = Q16_MIN;
      cfg[REG_DRIVE_MAX]       = Q16_MAX;
      cfg[REG_DRIVE_MIN]       = Q16_MIN;
      write_regs(cfg);
      send_word(KIND_UPDATE, '0, 32'sh0001_0000);
      send_word(KIND_UPDATE, '0, 32'sh0001_0000);
      send_word(KIND_UPDATE, 32'sh0000_4000, 32'sh0001_0000);
      send_word(KIND_CLEAR, 32'sh1234_5678, 32'shEDCB_A987);
      send_word(KIND_UPDATE, '0, 32'sh0001_0000);
      end_words();
      wait_idle();

      // random phases: fresh settings, then a drifting loop with noise and clears
      while (words_sent < 1850) begin
         cfg[REG_GAIN_P]          = pick_q16();
         cfg[REG_GAIN_I]          = pick_q16();
         cfg[REG_GAIN_D_PER_STEP] = pick_q16();
         case ($urandom_range(0, 3))
            0: cfg[REG_STEP_TIME] = '0;
            1: cfg[REG_STEP_TIME] = $urandom_range(1, 32'h0002_0000);
            2: cfg[REG_STEP_TIME] = $urandom;
            default: cfg[REG_STEP_TIME] = 32'h0001_0000;
         endcase
         pick_window(lo, hi);
         cfg[REG_INTEGRAL_MIN] = lo;
         cfg[REG_INTEGRAL_MAX] = hi;
         pick_window(lo, hi);
         cfg[REG_DRIVE_MIN] = lo;
         cfg[REG_DRIVE_MAX] = hi;
         write_regs(cfg);

         no_gaps = ($urandom_range(0, 3) == 0);
         target  = pick_q16();
         level   = pick_q16();
         n       = $urandom_range(60, 200);
         repeat (n) begin
            case ($urandom_range(0, 19))
               0: send_word(KIND_CLEAR, q16_type'($urandom), q16_type'($urandom));
               1, 2: send_word(KIND_UPDATE, pick_q16(), pick_q16());
               3: send_word(KIND_UPDATE, q16_type'($urandom), q16_type'($urandom));
               default: begin
                  level = level + q16_type'($urandom_range(0, 32'h0002_0000))
                          - 32'sh0001_0000;
                  send_word(KIND_UPDATE, level, target);
               end
            endcase
         end
         end_words();
         wait_idle();
      end
      no_gaps = 1'b0;

      // let any stray drive word show up
      repeat (30) @(posedge clock);
      if (sb.pending_drive.size() != 0)
         sb.report_mismatch($sformatf("%0d drive words never arrived",
                                      sb.pending_drive.size()));

      $display("covered %0d words (%0d clears) over %0d register writes",
               words_sent, clears_sent, csr_writes);
      $display("checked %0d drive words, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("pid_controller_clamped verification clean");
      else
         $display("pid_controller_clamped verification failed");
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #5_000_000;
      $display("timeout waiting on the controller");
      $display("pid_controller_clamped verification failed");
      $finish;
   end

endmodule

// File: pid_controller_clamped.f
rtl/core/pidc_pkg.sv
rtl/core/pidc_mul.sv
rtl/core/pidc_core.sv
rtl/core/pid_controller_clamped.sv
tb/sv/tb_pid_controller_clamped.sv
